/* src/aliquot_sum_perfect_amicable_unit_assert.svh */
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ALIQUOT_SUM_PERFECT_AMICABLE_UNIT_ASSERT_SVH
`define ALIQUOT_SUM_PERFECT_AMICABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define ASP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/asp_pkg.sv */
package asp_pkg;

  localparam int NUMBER_BITS_DEF = 24;
  localparam int SUM_W           = 27;
  localparam int COUNT_W         = 13;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_ACCEPT   = 4'd0;
  localparam step_t ST_INIT     = 4'd1;
  localparam step_t ST_TEST     = 4'd2;
  localparam step_t ST_DSTART   = 4'd3;
  localparam step_t ST_DWAIT    = 4'd4;
  localparam step_t ST_ACCUM    = 4'd5;
  localparam step_t ST_PASS_END = 4'd6;
  localparam step_t ST_SETUP2   = 4'd7;
  localparam step_t ST_LOOP2    = 4'd8;
  localparam step_t ST_EMIT     = 4'd9;
  localparam step_t ST_RETURN   = 4'd10;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_DSTART,
    OP_ACCUM,
    OP_PASS_END,
    OP_SETUP2,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_X_SMALL,
    COND_SQ_OVER,
    COND_DIV_BUSY,
    COND_PASS2,
    COND_SKIP2,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic x_small;
    logic sq_over;
    logic div_busy;
    logic pass2;
    logic skip2;
    logic out_blocked;
  } dp_flags_t;

  // control store: on a true condition jump to target, else fall through
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    case (pc)
      ST_ACCEPT:   w = '{OP_ACCEPT,   COND_NO_INPUT,    ST_ACCEPT};
      ST_INIT:     w = '{OP_INIT,     COND_X_SMALL,     ST_PASS_END};
      ST_TEST:     w = '{OP_NOP,      COND_SQ_OVER,     ST_PASS_END};
      ST_DSTART:   w = '{OP_DSTART,   COND_NEVER,       ST_ACCEPT};
      ST_DWAIT:    w = '{OP_NOP,      COND_DIV_BUSY,    ST_DWAIT};
      ST_ACCUM:    w = '{OP_ACCUM,    COND_ALWAYS,      ST_TEST};
      ST_PASS_END: w = '{OP_PASS_END, COND_PASS2,       ST_EMIT};
      ST_SETUP2:   w = '{OP_SETUP2,   COND_SKIP2,       ST_EMIT};
      ST_LOOP2:    w = '{OP_NOP,      COND_ALWAYS,      ST_INIT};
      ST_EMIT:     w = '{OP_EMIT,     COND_OUT_BLOCKED, ST_EMIT};
      ST_RETURN:   w = '{OP_NOP,      COND_ALWAYS,      ST_ACCEPT};
      default:     w = '{OP_NOP,      COND_ALWAYS,      ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

/* src/asp_if.sv */
interface asp_num_if #(
  parameter int NUMBER_BITS = asp_pkg::NUMBER_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface asp_res_if;
  logic                         valid;
  logic                         ready;
  logic [asp_pkg::SUM_W-1:0]    divisor_sum;
  logic [asp_pkg::COUNT_W-1:0]  divisor_count;
  logic                         is_perfect;
  logic                         is_amicable;

  modport source (output valid, output divisor_sum, output divisor_count,
                  output is_perfect, output is_amicable, input ready);
  modport sink   (input valid, input divisor_sum, input divisor_count,
                  input is_perfect, input is_amicable, output ready);
endinterface

/* src/asp_div.sv */
module asp_div #(
  parameter int W = asp_pkg::NUMBER_BITS_DEF + 3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, div_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (start) begin
      cnt_nxt = CW'(W);
      quo_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

/* src/asp_seq.sv */
module asp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  asp_pkg::dp_flags_t flags,
  output asp_pkg::op_t       op
);
  import asp_pkg::*;

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = ucode_rom(pc_r);
    case (uw.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = flags.no_input;
      COND_X_SMALL:     take = flags.x_small;
      COND_SQ_OVER:     take = flags.sq_over;
      COND_DIV_BUSY:    take = flags.div_busy;
      COND_PASS2:       take = flags.pass2;
      COND_SKIP2:       take = flags.skip2;
      COND_OUT_BLOCKED: take = flags.out_blocked;
      default:          take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = uw.op;
endmodule

/* src/asp_dp.sv */
module asp_dp #(
  parameter int NUMBER_BITS = asp_pkg::NUMBER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  asp_pkg::op_t             op,
  input  logic                     in_valid,
  input  logic [NUMBER_BITS-1:0]   in_number,
  input  logic                     out_blocked,
  output logic                     in_ready,
  output asp_pkg::dp_flags_t       flags,
  output logic [NUMBER_BITS+2:0]   sum1,
  output logic [NUMBER_BITS-1:0]   cnt1,
  output logic                     perfect,
  output logic                     amicable
);
  import asp_pkg::*;

  localparam int X_W   = NUMBER_BITS + 3;
  localparam int ACC_W = NUMBER_BITS + 6;
  localparam int CNT_W = NUMBER_BITS;

  logic [NUMBER_BITS-1:0] n_r, n_nxt;
  logic [X_W-1:0]         x_r, x_nxt;
  logic [X_W-1:0]         d_r, d_nxt;
  logic [X_W:0]           sq_r, sq_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [X_W-1:0]         s1_r, s1_nxt;
  logic [CNT_W-1:0]       c1_r, c1_nxt;
  logic                   pass2_r, pass2_nxt;
  logic                   perfect_r, perfect_nxt;
  logic                   amicable_r, amicable_nxt;

  logic                   div_busy;
  logic [X_W-1:0]         quo;
  logic [X_W-1:0]         rem;
  logic                   hit;
  logic                   pair;
  logic                   n_big;
  logic                   acc_eq_n;

  asp_div #(.W(X_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (op == OP_DSTART),
    .dividend  (x_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    hit      = (rem == '0);
    pair     = (quo != d_r) && (d_r != X_W'(1));
    n_big    = (n_r >= NUMBER_BITS'(2));
    acc_eq_n = (acc_r == ACC_W'(n_r));

    n_nxt        = n_r;
    x_nxt        = x_r;
    d_nxt        = d_r;
    sq_nxt       = sq_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    s1_nxt       = s1_r;
    c1_nxt       = c1_r;
    pass2_nxt    = pass2_r;
    perfect_nxt  = perfect_r;
    amicable_nxt = amicable_r;

    case (op)
      OP_ACCEPT: begin
        if (in_valid) begin
          n_nxt        = in_number;
          x_nxt        = X_W'(in_number);
          pass2_nxt    = 1'b0;
          perfect_nxt  = 1'b0;
          amicable_nxt = 1'b0;
        end
      end
      OP_INIT: begin
        d_nxt   = X_W'(1);
        sq_nxt  = (X_W+1)'(1);
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      OP_ACCUM: begin
        if (hit) begin
          acc_nxt = acc_r + ACC_W'(d_r) + (pair ? ACC_W'(quo) : ACC_W'(0));
          cnt_nxt = cnt_r + (pair ? CNT_W'(2) : CNT_W'(1));
        end
        d_nxt  = d_r + X_W'(1);
        sq_nxt = sq_r + {d_r, 1'b1};
      end
      OP_PASS_END: begin
        if (!pass2_r) begin
          s1_nxt      = X_W'(acc_r);
          c1_nxt      = cnt_r;
          perfect_nxt = acc_eq_n && n_big;
        end else begin
          amicable_nxt = acc_eq_n;
        end
      end
      OP_SETUP2: begin
        x_nxt     = s1_r;
        pass2_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    x_r        <= x_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    s1_r       <= s1_nxt;
    c1_r       <= c1_nxt;
    pass2_r    <= pass2_nxt;
    perfect_r  <= perfect_nxt;
    amicable_r <= amicable_nxt;
  end

  always_comb begin
    flags.no_input    = !in_valid;
    flags.x_small     = (x_r < X_W'(2));
    flags.sq_over     = (sq_r > {1'b0, x_r});
    flags.div_busy    = div_busy;
    flags.pass2       = pass2_r;
    flags.skip2       = perfect_r || !n_big;
    flags.out_blocked = out_blocked;
  end

  assign in_ready = (op == OP_ACCEPT);
  assign sum1     = s1_r;
  assign cnt1     = c1_r;
  assign perfect  = perfect_r;
  assign amicable = amicable_r;
endmodule

/* src/aliquot_sum_perfect_amicable_unit.sv */
// Aliquot sum unit: for each number n it returns the sum and count of the proper
// divisors of n, a perfect flag (sum equals n) and an amicable flag (the divisor
// sum of the sum is n again and n is not perfect); 0 and 1 give all zeros, and
// sum and count saturate at their field maxima. A small control store steps a
// datapath through trial division by d = 1, 2, ... while d*d stays within the
// operand, first over n and then over its sum. Each trial divisor passes through
// the one shared bit-serial divider; perfect numbers and those below 2 skip the
// second pass. One number is in work at a time. The result sits in an output
// register, so the unit goes back to take the next number once the result is
// written, even before it is read.
module aliquot_sum_perfect_amicable_unit #(
  parameter int NUMBER_BITS = asp_pkg::NUMBER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  asp_num_if.sink    in_chan,
  asp_res_if.source  out_chan
);
  import asp_pkg::*;

  localparam int X_W    = NUMBER_BITS + 3;
  localparam int SEXT_W = (X_W > SUM_W) ? X_W : SUM_W;
  localparam int CEXT_W = (NUMBER_BITS > COUNT_W) ? NUMBER_BITS : COUNT_W;

  op_t                    op;
  dp_flags_t              flags;
  logic [X_W-1:0]         sum1;
  logic [NUMBER_BITS-1:0] cnt1;
  logic                   perfect;
  logic                   amicable;
  logic                   out_blocked;
  logic                   emit;
  logic [SEXT_W-1:0]      sum_ext;
  logic [CEXT_W-1:0]      cnt_ext;

  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]       out_sum_r, out_sum_nxt;
  logic [COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                   out_perf_r, out_perf_nxt;
  logic                   out_amic_r, out_amic_nxt;

  asp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  asp_dp #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .in_valid    (in_chan.valid),
    .in_number   (in_chan.number[NUMBER_BITS-1:0]),
    .out_blocked (out_blocked),
    .in_ready    (in_chan.ready),
    .flags       (flags),
    .sum1        (sum1),
    .cnt1        (cnt1),
    .perfect     (perfect),
    .amicable    (amicable)
  );

  always_comb begin
    out_blocked = out_valid_r && !out_chan.ready;
    emit        = (op == OP_EMIT) && !out_blocked;
    sum_ext     = SEXT_W'(sum1);
    cnt_ext     = CEXT_W'(cnt1);

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_sum_nxt   = out_sum_r;
    out_cnt_nxt   = out_cnt_r;
    out_perf_nxt  = out_perf_r;
    out_amic_nxt  = out_amic_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = (sum_ext > SEXT_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
      out_cnt_nxt   = (cnt_ext > CEXT_W'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_W-1:0];
      out_perf_nxt  = perfect;
      out_amic_nxt  = amicable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r  <= out_sum_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_perf_r <= out_perf_nxt;
    out_amic_r <= out_amic_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.divisor_sum   = out_sum_r;
  assign out_chan.divisor_count = out_cnt_r;
  assign out_chan.is_perfect    = out_perf_r;
  assign out_chan.is_amicable   = out_amic_r;
endmodule

/* src/asp_chk.sv */
`include "aliquot_sum_perfect_amicable_unit_assert.svh"

module asp_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [asp_pkg::SUM_W-1:0]    out_divisor_sum,
  input logic [asp_pkg::COUNT_W-1:0]  out_divisor_count,
  input logic                         out_is_perfect,
  input logic                         out_is_amicable
);
  import asp_pkg::*;

  `ASP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_divisor_sum) && $stable(out_divisor_count), "stalled result changed")
  `ASP_ASSERT_IMP(a_flags_excl, out_valid, !(out_is_perfect && out_is_amicable), "perfect and amicable both set")
  `ASP_ASSERT_IMP(a_flag_nonzero, out_valid && (out_is_perfect || out_is_amicable), (out_divisor_count != '0) && (out_divisor_sum != '0), "flag set with empty divisor sum")
endmodule

bind aliquot_sum_perfect_amicable_unit asp_chk u_asp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_divisor_sum   (out_chan.divisor_sum),
  .out_divisor_count (out_chan.divisor_count),
  .out_is_perfect    (out_chan.is_perfect),
  .out_is_amicable   (out_chan.is_amicable)
);
